// ===== rtl/pttsu_pkg.sv =====
// Shared types and codes for the periodic task tick scheduler.
package pttsu_pkg;

  // Command codes carried by request_t.command.
  localparam logic [1:0] CMD_REGISTER = 2'd0;
  localparam logic [1:0] CMD_TICK     = 2'd1;
  localparam logic [1:0] CMD_ADJUST   = 2'd2;
  localparam logic [1:0] CMD_UNUSED   = 2'd3;

  // Result kinds carried by result_t.kind.
  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_FIRED  = 2'd1;
  localparam logic [1:0] KIND_IDLE   = 2'd2;
  localparam logic [1:0] KIND_ADJUST = 2'd3;

  // Register ack status.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Most fired results reported for one tick.
  localparam int MAX_RESULTS = 32;
  localparam int FIRE_CNT_W  = 6;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] period;
    logic [15:0] run_threshold;
    logic [15:0] sleep_ticks;
  } request_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       status;
    logic [4:0] task_index;
    logic       last;
  } result_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic latch;    // capture the accepted request, rewind the walk
    logic reg_wr;   // append a channel and emit the ack
    logic walk_rd;  // read the channel at the walk index
    logic finish;   // emit the closing result of a tick or adjust
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic empty;     // no channels in the table
    logic idx_last;  // walk index sits on the last used channel
  } dp_stat_t;

endpackage

// ===== rtl/pttsu_dp.sv =====
// Datapath: channel table memory, walk pipeline, fire tracking and result register.
module pttsu_dp #(
  parameter int MAX_TASKS   = 32,
  parameter int PERIOD_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  pttsu_pkg::request_t request,
  input  pttsu_pkg::ctrl_cmd_t cmd,
  output pttsu_pkg::dp_stat_t stat,
  output logic                strobe,
  output pttsu_pkg::result_t  result
);

  localparam int IW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNTW = $clog2(MAX_TASKS + 1);
  localparam int CW   = (PERIOD_BITS > 16) ? PERIOD_BITS : 16;
  localparam int PB   = PERIOD_BITS;
  localparam int FW   = pttsu_pkg::FIRE_CNT_W;

  pttsu_pkg::request_t req;
  logic [CNTW-1:0]     entry_count;
  logic [IW-1:0]       idx;
  logic [2*PB-1:0]     mem [MAX_TASKS];
  logic [2*PB-1:0]     mem_q;
  logic                s1_vld;
  logic [IW-1:0]       s1_idx;
  logic                pend_vld;
  logic [IW-1:0]       pend_idx;
  logic [FW-1:0]       fire_cnt;

  logic                full;
  logic [CW-1:0]       per_ext;
  logic [PB-1:0]       per_in;
  logic [PB-1:0]       q_per;
  logic [PB-1:0]       q_cd;
  logic [CW-1:0]       q_cd_ext;
  logic [CW-1:0]       sleep_ext;
  logic [CW-1:0]       adj_diff;
  logic                eligible;
  logic                fire;
  logic                fire_keep;
  logic [PB-1:0]       cd_new;
  logic                mem_we;
  logic [IW-1:0]       mem_wa;
  logic [2*PB-1:0]     mem_wd;
  logic                strobe_next;
  pttsu_pkg::result_t  result_next;

  assign full           = (entry_count == CNTW'(MAX_TASKS));
  assign stat.empty     = (entry_count == '0);
  assign stat.idx_last  = ((CNTW'(idx) + CNTW'(1)) == entry_count);

  // Truncate or widen the request period to the stored width.
  assign per_ext = CW'(req.period);
  assign per_in  = per_ext[PB-1:0];

  assign q_per     = mem_q[2*PB-1:PB];
  assign q_cd      = mem_q[PB-1:0];
  assign q_cd_ext  = CW'(q_cd);
  assign sleep_ext = CW'(req.sleep_ticks);
  assign adj_diff  = q_cd_ext - sleep_ext;
  assign eligible  = (CW'(q_per) > CW'(req.run_threshold));

  assign fire      = s1_vld && (req.command == pttsu_pkg::CMD_TICK) && (q_cd == '0);
  assign fire_keep = fire && (fire_cnt < FW'(pttsu_pkg::MAX_RESULTS));

  always_comb begin
    cd_new = q_cd;
    if (req.command == pttsu_pkg::CMD_TICK) begin
      cd_new = (q_cd == '0) ? q_per : (q_cd - PB'(1));
    end else if (eligible) begin
      cd_new = (q_cd_ext > sleep_ext) ? adj_diff[PB-1:0] : '0;
    end
  end

  assign mem_we = (cmd.reg_wr && !full) || s1_vld;
  assign mem_wa = s1_vld ? s1_idx : entry_count[IW-1:0];
  assign mem_wd = s1_vld ? {q_per, cd_new} : {per_in, per_in};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.walk_rd) begin
      mem_q <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req <= request;
    end
    if (cmd.latch) begin
      idx <= '0;
    end else if (cmd.walk_rd) begin
      idx <= idx + IW'(1);
    end
    s1_idx <= idx;
    if (fire_keep) begin
      pend_idx <= s1_idx;
    end
    result <= result_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      s1_vld      <= 1'b0;
      pend_vld    <= 1'b0;
      fire_cnt    <= '0;
      strobe      <= 1'b0;
    end else begin
      s1_vld <= cmd.walk_rd;
      strobe <= strobe_next;
      if (cmd.reg_wr && !full) begin
        entry_count <= entry_count + CNTW'(1);
      end
      if (cmd.latch) begin
        pend_vld <= 1'b0;
        fire_cnt <= '0;
      end else if (fire_keep) begin
        pend_vld <= 1'b1;
        fire_cnt <= fire_cnt + FW'(1);
      end
    end
  end

  // Result selection: a new firing pushes out the held one as a non-final result.
  always_comb begin
    strobe_next            = 1'b0;
    result_next.kind       = pttsu_pkg::KIND_ACK;
    result_next.status     = pttsu_pkg::STATUS_OK;
    result_next.task_index = '0;
    result_next.last       = 1'b0;
    priority if (cmd.reg_wr) begin
      strobe_next        = 1'b1;
      result_next.last   = 1'b1;
      result_next.status = full ? pttsu_pkg::STATUS_FULL : pttsu_pkg::STATUS_OK;
      result_next.task_index = full ? 5'd0 : 5'(entry_count);
    end else if (cmd.finish) begin
      strobe_next      = 1'b1;
      result_next.last = 1'b1;
      if (pend_vld) begin
        result_next.kind       = pttsu_pkg::KIND_FIRED;
        result_next.task_index = 5'(pend_idx);
      end else if (req.command == pttsu_pkg::CMD_TICK) begin
        result_next.kind = pttsu_pkg::KIND_IDLE;
      end else begin
        result_next.kind = pttsu_pkg::KIND_ADJUST;
      end
    end else if (fire_keep && pend_vld) begin
      strobe_next            = 1'b1;
      result_next.kind       = pttsu_pkg::KIND_FIRED;
      result_next.task_index = 5'(pend_idx);
    end else begin
      strobe_next = 1'b0;
    end
  end

endmodule

// ===== rtl/pttsu_ctrl.sv =====
// Controller: sequences register, tick walk and sleep-adjust walk.
module pttsu_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [1:0]           command,
  input  pttsu_pkg::dp_stat_t  stat,
  output pttsu_pkg::ctrl_cmd_t cmd,
  output logic                 busy
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_REG  = 3'd1;
  localparam logic [2:0] ST_WALK = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          unique case (command)
            pttsu_pkg::CMD_REGISTER: state_next = ST_REG;
            pttsu_pkg::CMD_TICK,
            pttsu_pkg::CMD_ADJUST:   state_next = stat.empty ? ST_FIN : ST_WALK;
            default:                 state_next = ST_IDLE;
          endcase
        end
      end
      ST_REG: begin
        cmd.reg_wr = 1'b1;
        state_next = ST_IDLE;
      end
      ST_WALK: begin
        cmd.walk_rd = 1'b1;
        if (stat.idx_last) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/periodic_task_tick_scheduler_unit.sv =====
// Top level of the periodic task tick scheduler: controller plus datapath.
// Register transaction: busy while in ST_REG, which registers the ack into result.
// Tick / adjust: ST_WALK reads one used channel per cycle through one memory read port,
// then ST_WAIT, then ST_FIN registers the closing result (empty table: ST_FIN only).
// A new transaction is taken the cycle busy drops; results cannot be stalled.
// Synchronous reset empties the table; channel storage itself is not cleared.
module periodic_task_tick_scheduler_unit #(
  parameter int MAX_TASKS   = 32,
  parameter int PERIOD_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  pttsu_pkg::request_t request,
  output logic                busy,
  output logic                strobe,
  output pttsu_pkg::result_t  result
);

  // Command and status between the sequencer and the datapath.
  pttsu_pkg::ctrl_cmd_t cmd;
  pttsu_pkg::dp_stat_t  stat;

  // Sequencer: accept a transaction, then step register or walk phases.
  pttsu_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (request.command),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  // Datapath: hold the channel table, walk it one entry per cycle, and
  // drive at most one registered result per cycle. A firing channel is held back
  // until the next firing or the end of the walk decides its last flag.
  pttsu_dp #(
    .MAX_TASKS   (MAX_TASKS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .strobe  (strobe),
    .result  (result)
  );

  // Every completed transaction ends with a final result as busy drops.
  a_fall_has_last: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> (strobe && result.last))
    else $error("busy dropped without a final result");

  // A final result is never followed directly by another result.
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last) |=> !strobe)
    else $error("result strobed right after a final result");

  // A valid command makes the block busy on the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (request.command != pttsu_pkg::CMD_UNUSED)) |=> busy)
    else $error("accepted command did not raise busy");

  // Closing results without a channel carry a zero index and status.
  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    (strobe && ((result.kind == pttsu_pkg::KIND_IDLE) ||
                (result.kind == pttsu_pkg::KIND_ADJUST)))
      |-> (result.task_index == 5'd0 && result.status == 1'b0 && result.last))
    else $error("idle or adjust result carries channel fields");

endmodule

// ===== tb/pttsu_checker.sv =====
// Result checker for the periodic task tick scheduler: predicts and compares every result.
module pttsu_checker #(
  parameter int MAX_TASKS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  pttsu_pkg::request_t request,
  input  logic                strobe,
  input  pttsu_pkg::result_t  result,
  output int                  fail_count,
  output int                  pending,
  output int                  fired_count,
  output int                  full_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0]        reload_period [MAX_TASKS];
  logic [15:0]        countdown [MAX_TASKS];
  int                 used_channels;
  int                 errors;
  int                 fired_seen;
  int                 full_acks;
  pttsu_pkg::result_t expected_results [$];

  function automatic pttsu_pkg::result_t make_result(logic [1:0] kind, logic status,
                                                     logic [4:0] idx, logic last);
    pttsu_pkg::result_t r;
    r.kind       = kind;
    r.status     = status;
    r.task_index = idx;
    r.last       = last;
    return r;
  endfunction

  function automatic string describe(pttsu_pkg::result_t r);
    return $sformatf("kind=%0d status=%0d index=%0d last=%0d",
                     r.kind, r.status, r.task_index, r.last);
  endfunction

  // Advance the channel table by one transaction and queue what it produces.
  task automatic schedule_request(input pttsu_pkg::request_t req);
    int                 i;
    int                 fired;
    pttsu_pkg::result_t closing;
    fired = 0;
    case (req.command)
      pttsu_pkg::CMD_REGISTER: begin
        if (used_channels >= MAX_TASKS) begin
          expected_results.push_back(make_result(pttsu_pkg::KIND_ACK,
                                                 pttsu_pkg::STATUS_FULL, 5'd0, 1'b1));
          full_acks++;
        end else begin
          reload_period[used_channels] = req.period;
          countdown[used_channels]     = req.period;
          expected_results.push_back(make_result(pttsu_pkg::KIND_ACK, pttsu_pkg::STATUS_OK,
                                                 5'(used_channels), 1'b1));
          used_channels++;
        end
      end
      pttsu_pkg::CMD_TICK: begin
        for (i = 0; i < used_channels; i++) begin
          if (countdown[i] != 16'd0) begin
            countdown[i] = countdown[i] - 16'd1;
          end else begin
            countdown[i] = reload_period[i];
            if (fired < pttsu_pkg::MAX_RESULTS) begin
              expected_results.push_back(make_result(pttsu_pkg::KIND_FIRED,
                                                     pttsu_pkg::STATUS_OK, 5'(i), 1'b0));
              fired++;
            end
          end
        end
        if (fired == 0) begin
          expected_results.push_back(make_result(pttsu_pkg::KIND_IDLE,
                                                 pttsu_pkg::STATUS_OK, 5'd0, 1'b1));
        end else begin
          closing      = expected_results.pop_back();
          closing.last = 1'b1;
          expected_results.push_back(closing);
        end
      end
      pttsu_pkg::CMD_ADJUST: begin
        for (i = 0; i < used_channels; i++) begin
          if (reload_period[i] > req.run_threshold) begin
            if (countdown[i] > req.sleep_ticks) countdown[i] = countdown[i] - req.sleep_ticks;
            else countdown[i] = 16'd0;
          end
        end
        expected_results.push_back(make_result(pttsu_pkg::KIND_ADJUST,
                                               pttsu_pkg::STATUS_OK, 5'd0, 1'b1));
      end
      default: begin
      end
    endcase
  endtask

  initial begin
    used_channels = 0;
    errors        = 0;
    fired_seen    = 0;
    full_acks     = 0;
  end

  always @(posedge clk) begin
    pttsu_pkg::result_t want;
    if (rst) begin
      used_channels = 0;
      expected_results.delete();
    end else begin
      if (start && !busy) schedule_request(request);
      if (strobe) begin
        if (result.kind == pttsu_pkg::KIND_FIRED) fired_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %s, none expected", $time, describe(result));
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (result.kind !== want.kind || result.status !== want.status ||
              result.task_index !== want.task_index || result.last !== want.last) begin
            $display("%0t: expected %s, got %s", $time, describe(want), describe(result));
            errors++;
          end
        end
      end
    end
    fail_count  <= errors;
    pending     <= expected_results.size();
    fired_count <= fired_seen;
    full_count  <= full_acks;
  end

endmodule

// ===== tb/testbench.sv =====
// Stimulus and verdict for the periodic task tick scheduler.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_TASKS       = 32;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int SETTLE_CYCLES   = 40;

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  pttsu_pkg::request_t request;
  logic                busy;
  logic                strobe;
  pttsu_pkg::result_t  result;

  int fail_count;
  int pending;
  int fired_count;
  int full_count;
  int quiet_cycles = 0;
  int idle_pct = 0;
  int accepted_items = 0;

  // 4 ns clock, high half first after the opening low half.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  periodic_task_tick_scheduler_unit #(
    .MAX_TASKS  (MAX_TASKS),
    .PERIOD_BITS(16)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .request(request),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  pttsu_checker #(
    .MAX_TASKS(MAX_TASKS)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .request    (request),
    .strobe     (strobe),
    .result     (result),
    .fail_count (fail_count),
    .pending    (pending),
    .fired_count(fired_count),
    .full_count (full_count)
  );

  // Watchdog: end the run if neither a transaction nor a result moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("periodic_task_tick_scheduler_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic pttsu_pkg::request_t request_of(logic [1:0] command, logic [15:0] period,
                                                     logic [15:0] run_threshold,
                                                     logic [15:0] sleep_ticks);
    pttsu_pkg::request_t r;
    r.command       = command;
    r.period        = period;
    r.run_threshold = run_threshold;
    r.sleep_ticks   = sleep_ticks;
    return r;
  endfunction

  // Present one transaction and hold it until the block takes it, then idle
  // the sender for a random stretch according to the current phase.
  task automatic issue(input pttsu_pkg::request_t req);
    start   <= 1'b1;
    request <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    accepted_items++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Drop start and hold off until every predicted result has been seen.
  task automatic hold_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    pttsu_pkg::request_t req;
    int                  phase;
    int                  sent;
    int                  pick;
    start   <= 1'b0;
    request <= '0;
    rst     <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part: period extremes, a channel that fires on every tick,
    // clamping of countdowns at zero, thresholds that exclude every channel,
    // and the unused command, which must produce no result at all.
    issue(request_of(pttsu_pkg::CMD_REGISTER, 16'd0, 16'd0, 16'd0));
    issue(request_of(pttsu_pkg::CMD_REGISTER, 16'hFFFF, 16'd0, 16'd0));
    issue(request_of(pttsu_pkg::CMD_REGISTER, 16'd1, 16'd0, 16'd0));
    issue(request_of(pttsu_pkg::CMD_REGISTER, 16'd2, 16'd0, 16'd0));
    issue(request_of(pttsu_pkg::CMD_TICK, 16'd0, 16'd0, 16'd0));
    issue(request_of(pttsu_pkg::CMD_TICK, 16'd0, 16'd0, 16'd0));
    issue(request_of(pttsu_pkg::CMD_TICK, 16'd0, 16'd0, 16'd0));
    issue(request_of(pttsu_pkg::CMD_ADJUST, 16'd0, 16'd0, 16'hFFFF));
    issue(request_of(pttsu_pkg::CMD_TICK, 16'd0, 16'd0, 16'd0));
    issue(request_of(pttsu_pkg::CMD_ADJUST, 16'd0, 16'hFFFF, 16'hFFFF));
    issue(request_of(pttsu_pkg::CMD_ADJUST, 16'd0, 16'd1, 16'd1));
    issue(request_of(pttsu_pkg::CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    issue(request_of(pttsu_pkg::CMD_TICK, 16'd0, 16'd0, 16'd0));
    issue(request_of(pttsu_pkg::CMD_REGISTER, 16'd3, 16'd0, 16'd0));
    issue(request_of(pttsu_pkg::CMD_ADJUST, 16'd0, 16'd0, 16'd0));
    issue(request_of(pttsu_pkg::CMD_TICK, 16'd0, 16'd0, 16'd0));
    issue(request_of(pttsu_pkg::CMD_TICK, 16'd0, 16'd0, 16'd0));
    issue(request_of(pttsu_pkg::CMD_ADJUST, 16'd0, 16'd2, 16'd5));
    issue(request_of(pttsu_pkg::CMD_TICK, 16'd0, 16'd0, 16'd0));

    // Random part in four phases: no idling, heavy sender idling, no idling
    // right after a full drain, and light sender idling. Mostly short periods
    // so that channels fire often once the table has filled up; registers keep
    // coming after that to exercise the table-full ack.
    for (phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 87 : (phase == 3) ? 33 : 0;
      if (phase == 2) hold_until_drained();
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        req.command = (pick < 15) ? pttsu_pkg::CMD_REGISTER :
                      (pick < 72) ? pttsu_pkg::CMD_TICK :
                      (pick < 95) ? pttsu_pkg::CMD_ADJUST : pttsu_pkg::CMD_UNUSED;
        if (req.command == pttsu_pkg::CMD_REGISTER) begin
          pick = $urandom_range(99);
          req.period = (pick < 70) ? 16'($urandom_range(15)) :
                       (pick < 90) ? 16'($urandom_range(300, 16)) : 16'($urandom_range(65535));
        end else begin
          req.period = 16'($urandom_range(65535));
        end
        req.run_threshold = $urandom_range(1) ? 16'($urandom_range(20)) :
                                                16'($urandom_range(65535));
        req.sleep_ticks   = $urandom_range(1) ? 16'($urandom_range(10)) :
                                                16'($urandom_range(65535));
        issue(req);
        // Ignored commands do not count toward the phase length.
        if (req.command != pttsu_pkg::CMD_UNUSED) sent++;
      end
    end

    // Wind down: wait out every predicted result, then let the block settle
    // so that any stray result still shows up in the checker.
    idle_pct = 0;
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d transactions over four idle phases with %0d channel firings",
             accepted_items, fired_count);
    $display("and %0d table-full register acks.", full_count);
    if (fail_count == 0) begin
      $display("periodic_task_tick_scheduler_unit: match");
    end else begin
      $display("periodic_task_tick_scheduler_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pttsu_pkg.sv
rtl/pttsu_dp.sv
rtl/pttsu_ctrl.sv
rtl/periodic_task_tick_scheduler_unit.sv
tb/pttsu_checker.sv
tb/testbench.sv
